// ----- rtl/tlr_pkg.sv -----
// Thick line rasterizer package: register indexes, opcodes, reset values.
// No dependencies; imported by thick_line_rasterizer_unit.
`timescale 1ns / 1ps

package tlr_pkg;

	localparam int REG_BITS       = 15;
	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_RADIUS_DEF = 127;

	typedef logic [REG_BITS-1:0] dim_t;

	localparam dim_t WIDTH_RESET  = dim_t'(640);
	localparam dim_t HEIGHT_RESET = dim_t'(480);

	// configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// item opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_NEXT  = 1'b1;

	localparam logic [2:0] OCT_LAST = 3'd7;

endpackage

// ----- rtl/thick_line_rasterizer_unit.sv -----
// A pixel write appears on the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; input stalls only while a held result is stalled.
// A start item or a next item while idle is consumed and gives no result.
// Reset (arst_n low, async) clears the walker to idle and the image size to 640 x 480.
// Thick line rasterizer: Bresenham line walk with a Bresenham circle brush.
// Depends on tlr_pkg.
`timescale 1ns / 1ps

module thick_line_rasterizer_unit import tlr_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration
	input  logic                         cfg_write,
	input  logic                         cfg_index,
	input  logic [REG_BITS-1:0]          cfg_data,
	// item channel
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         operation,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [7:0]                   thickness,
	// pixel channel
	output logic                         pixel_valid,
	input  logic                         pixel_stall,
	output logic signed [COORD_BITS:0]   pixel_x,
	output logic signed [COORD_BITS:0]   pixel_y,
	output logic                         visible,
	output logic                         last_write
);

	localparam int LW  = COORD_BITS + 1;             // line point
	localparam int DW  = COORD_BITS;                 // |dx|, |dy|, step count
	localparam int EW  = COORD_BITS + 3;             // line error
	localparam int RB  = $clog2(MAX_RADIUS + 1);     // radius
	localparam int CW  = RB + 2;                     // ring coordinates, signed
	localparam int DLW = RB + 4;                     // ring decision value
	localparam int PW  = ((LW > CW) ? LW : CW) + 1;  // pixel before truncation
	localparam int VW  = (PW > REG_BITS + 1) ? PW : REG_BITS + 1;

	// configuration
	dim_t width_q, height_q;

	// command state
	logic                   busy_q;
	logic signed [COORD_BITS-1:0] sp_x_q, sp_y_q;
	logic [DW-1:0]          lx_q, ly_q;
	logic                   neg_x_q, neg_y_q, x_major_q;
	logic [RB-1:0]          radius_q;
	logic signed [LW-1:0]   line_x_q, line_y_q;
	logic signed [EW-1:0]   err_q;
	logic [DW-1:0]          steps_q;
	logic signed [CW-1:0]   ring_x_q, ring_y_q;
	logic signed [DLW-1:0]  ring_d_q;
	logic [2:0]             oct_q;
	logic                   pass2_q, repeat_q, even_q;

	logic accept, take_start, take_next;

	assign item_stall = pixel_valid & pixel_stall;
	assign accept     = item_valid & ~item_stall;
	assign take_start = accept & (operation == OP_START);
	assign take_next  = accept & (operation == OP_NEXT) & busy_q;

	// ---------------- start decode ----------------
	logic signed [LW-1:0] st_dx, st_dy;
	logic [DW-1:0]        st_lx, st_ly, st_steps;
	logic                 st_xmaj;
	logic signed [EW-1:0] st_err;
	logic [7:0]           st_r8;
	logic [RB-1:0]        st_radius;

	always_comb begin
		st_dx   = LW'(end_x) - LW'(start_x);
		st_dy   = LW'(end_y) - LW'(start_y);
		st_lx   = st_dx[LW-1] ? DW'(-st_dx) : DW'(st_dx);
		st_ly   = st_dy[LW-1] ? DW'(-st_dy) : DW'(st_dy);
		st_xmaj = (st_ly <= st_lx);
		st_steps = st_xmaj ? st_lx : st_ly;
		st_err  = st_xmaj ? -EW'(st_lx) : -EW'(st_ly);
		// (t-1)/2 truncated toward zero, zero for t = 0
		st_r8   = (thickness == 8'd0) ? 8'd0 : ((thickness - 8'd1) >> 1);
		if (32'(st_r8) > 32'(MAX_RADIUS))
			st_radius = RB'(MAX_RADIUS);
		else
			st_radius = RB'(st_r8);
	end

	// ---------------- pixel of the current octant ----------------
	logic signed [PW-1:0] lxe, lye, cxe, cye, px, py;
	logic signed [VW-1:0] px_v, py_v, wid_v, hgt_v;
	logic                 vis;

	always_comb begin
		lxe = PW'(line_x_q);
		lye = PW'(line_y_q);
		cxe = PW'(ring_x_q);
		cye = PW'(ring_y_q);
		case (oct_q)
			3'd0: begin px = lxe + cxe; py = lye + cye; end
			3'd1: begin px = lxe + cxe; py = lye - cye; end
			3'd2: begin px = lxe - cxe; py = lye + cye; end
			3'd3: begin px = lxe - cxe; py = lye - cye; end
			3'd4: begin px = lxe + cye; py = lye + cxe; end
			3'd5: begin px = lxe + cye; py = lye - cxe; end
			3'd6: begin px = lxe - cye; py = lye + cxe; end
			default: begin px = lxe - cye; py = lye - cxe; end
		endcase
		px_v  = VW'(px);
		py_v  = VW'(py);
		wid_v = VW'($signed({1'b0, width_q}));
		hgt_v = VW'($signed({1'b0, height_q}));
		vis   = (px_v >= 0) && (py_v >= 0) && (px_v < wid_v) && (py_v < hgt_v);
	end

	// ---------------- circle stepper ----------------
	logic signed [DLW:0]   ring_s;
	logic signed [CW-1:0]  step_rx, step_ry;
	logic signed [DLW-1:0] step_rd, ring_d_init;
	logic                  ring_keep;

	always_comb begin
		// 2*(d+y)-1 <= 0 exactly when d+y <= 0
		ring_s = (DLW+1)'(ring_d_q) + (DLW+1)'(ring_y_q);
		if (ring_d_q < 0 && ring_s <= 0) begin
			step_rx = ring_x_q + CW'(1);
			step_ry = ring_y_q;
			step_rd = ring_d_q + DLW'(ring_x_q) + DLW'(ring_x_q) + DLW'(3);
		end else if (ring_d_q > 0 && ring_s > 0) begin
			step_rx = ring_x_q;
			step_ry = ring_y_q - CW'(1);
			step_rd = ring_d_q - DLW'(ring_y_q) - DLW'(ring_y_q) + DLW'(1);
		end else begin
			step_rx = ring_x_q + CW'(1);
			step_ry = ring_y_q - CW'(1);
			step_rd = ring_d_q + DLW'(ring_x_q) + DLW'(ring_x_q)
				- DLW'(ring_y_q) - DLW'(ring_y_q) + DLW'(4);
		end
		ring_keep   = (step_ry >= step_rx);
		ring_d_init = DLW'(1) - DLW'({1'b0, radius_q, 1'b0});
	end

	// ---------------- line stepper ----------------
	logic signed [EW-1:0] tw_lx, tw_ly, ls_e1, ls_err;
	logic signed [LW-1:0] ls_sx, ls_sy, ls_x, ls_y;

	always_comb begin
		tw_lx = EW'({1'b0, lx_q, 1'b0});
		tw_ly = EW'({1'b0, ly_q, 1'b0});
		ls_sx = neg_x_q ? -LW'(1) : LW'(1);
		ls_sy = neg_y_q ? -LW'(1) : LW'(1);
		ls_x  = line_x_q;
		ls_y  = line_y_q;
		if (x_major_q) begin
			ls_x  = line_x_q + ls_sx;
			ls_e1 = err_q + tw_ly;
			ls_err = ls_e1;
			if (ls_e1 > 0) begin
				ls_err = ls_e1 - tw_lx;
				ls_y   = line_y_q + ls_sy;
			end
		end else begin
			ls_y  = line_y_q + ls_sy;
			ls_e1 = err_q + tw_lx;
			ls_err = ls_e1;
			if (ls_e1 > 0) begin
				ls_err = ls_e1 - tw_ly;
				ls_x   = line_x_q + ls_sx;
			end
		end
	end

	// ---------------- advance ----------------
	logic [2:0]            n_oct;
	logic signed [CW-1:0]  n_rx, n_ry;
	logic signed [DLW-1:0] n_rd;
	logic signed [LW-1:0]  n_lx, n_ly;
	logic signed [EW-1:0]  n_err;
	logic [DW-1:0]         n_steps, p2_steps;
	logic                  n_pass2, n_repeat, more, shift_x;

	always_comb begin
		n_oct    = oct_q + 3'd1;
		n_rx     = ring_x_q;
		n_ry     = ring_y_q;
		n_rd     = ring_d_q;
		n_lx     = line_x_q;
		n_ly     = line_y_q;
		n_err    = err_q;
		n_steps  = steps_q;
		n_pass2  = pass2_q;
		n_repeat = repeat_q;
		more     = 1'b1;
		shift_x  = (lx_q <= ly_q);
		p2_steps = x_major_q ? lx_q : ly_q;
		if (oct_q == OCT_LAST) begin
			n_oct = 3'd0;
			n_rx  = step_rx;
			n_ry  = step_ry;
			n_rd  = step_rd;
			if (!ring_keep) begin
				n_rx = '0;
				n_ry = CW'(radius_q);
				n_rd = ring_d_init;
				if (repeat_q) begin
					n_repeat = 1'b0;
				end else if (steps_q != '0) begin
					n_lx    = ls_x;
					n_ly    = ls_y;
					n_err   = ls_err;
					n_steps = steps_q - DW'(1);
				end else if (!pass2_q && even_q) begin
					// second pass, shifted across the major axis
					n_pass2  = 1'b1;
					n_lx     = LW'(sp_x_q) + (shift_x ? LW'(1) : LW'(0));
					n_ly     = LW'(sp_y_q) + (shift_x ? LW'(0) : LW'(1));
					n_err    = x_major_q ? -EW'(lx_q) : -EW'(ly_q);
					n_steps  = p2_steps;
					n_repeat = (p2_steps == '0);
				end else begin
					more = 1'b0;
				end
			end
		end
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			oct_q    <= 3'd0;
			pass2_q  <= 1'b0;
			repeat_q <= 1'b0;
			even_q   <= 1'b0;
			ring_x_q <= '0;
			ring_y_q <= '0;
			ring_d_q <= '0;
		end else if (take_start) begin
			busy_q   <= 1'b1;
			oct_q    <= 3'd0;
			pass2_q  <= 1'b0;
			repeat_q <= (st_steps == '0);
			even_q   <= ~thickness[0];
			ring_x_q <= '0;
			ring_y_q <= CW'(st_radius);
			ring_d_q <= DLW'(1) - DLW'({1'b0, st_radius, 1'b0});
		end else if (take_next) begin
			busy_q   <= more;
			oct_q    <= n_oct;
			pass2_q  <= n_pass2;
			repeat_q <= n_repeat;
			ring_x_q <= n_rx;
			ring_y_q <= n_ry;
			ring_d_q <= n_rd;
		end
	end

	// line walker datapath
	always_ff @(posedge clk) begin
		if (take_start) begin
			sp_x_q    <= start_x;
			sp_y_q    <= start_y;
			lx_q      <= st_lx;
			ly_q      <= st_ly;
			neg_x_q   <= st_dx[LW-1];
			neg_y_q   <= st_dy[LW-1];
			x_major_q <= st_xmaj;
			radius_q  <= st_radius;
			line_x_q  <= LW'(start_x);
			line_y_q  <= LW'(start_y);
			err_q     <= st_err;
			steps_q   <= st_steps;
		end else if (take_next) begin
			line_x_q <= n_lx;
			line_y_q <= n_ly;
			err_q    <= n_err;
			steps_q  <= n_steps;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_valid <= 1'b0;
		else if (take_next)
			pixel_valid <= 1'b1;
		else if (!pixel_stall)
			pixel_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take_next) begin
			pixel_x    <= px[LW-1:0];
			pixel_y    <= py[LW-1:0];
			visible    <= vis;
			last_write <= ~more;
		end
	end

`ifndef NO_ASSERTIONS
	// idle walker always rests at the first octant
	a_idle_octant: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> oct_q == 3'd0)
		else $error("octant index nonzero while idle");

	// stored ring point never crosses the diagonal
	a_ring_order: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ring_y_q >= ring_x_q)
		else $error("ring point past diagonal");

	a_pass2_even: assert property (@(posedge clk) disable iff (!arst_n)
		pass2_q |-> even_q)
		else $error("second pass on odd thickness");

	// a transaction that yields no write leaves the result register empty
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !take_next) |=> !pixel_valid)
		else $error("result produced without a next transaction");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(take_next && !more) |=> !busy_q)
		else $error("walker busy after last write");
`endif

endmodule

// ----- dv/tb_thick_line_rasterizer_unit.sv -----
// Self-checking testbench for thick_line_rasterizer_unit: random line commands, checked
// against an in-bench model of the line walk and circle brush, with random stalls.
// Depends on tlr_pkg and the thick_line_rasterizer_unit RTL.
`timescale 1ns / 1ps

module tb_thick_line_rasterizer_unit;
	import tlr_pkg::*;

	localparam int ITEM_BUDGET    = 1950;
	localparam int PHASES         = 5;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 6;
	// held back per phase for the last command's overshoot and the closing command
	localparam int CLOSE_RESERVE  = 170;

	typedef struct packed {
		logic        op;
		logic [15:0] x0;
		logic [15:0] y0;
		logic [15:0] x1;
		logic [15:0] y1;
		logic [7:0]  thick;
	} line_item_t;

	typedef struct packed {
		logic [16:0] px;
		logic [16:0] py;
		logic        vis;
		logic        last;
	} pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic               cfg_index = CFG_WIDTH;
	dim_t               cfg_data = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               operation = OP_START;
	logic signed [15:0] start_x = '0;
	logic signed [15:0] start_y = '0;
	logic signed [15:0] end_x = '0;
	logic signed [15:0] end_y = '0;
	logic [7:0]         thickness = '0;
	logic               pixel_valid;
	logic               pixel_stall = 1'b0;
	logic signed [16:0] pixel_x;
	logic signed [16:0] pixel_y;
	logic               visible;
	logic               last_write;

	thick_line_rasterizer_unit dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	line_item_t pending_items[$];
	pixel_t     expected_pixels[$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         quiet_cycles = 0;
	int         phase_items = 0;
	bit         gen_busy = 1'b0;
	bit         item_taken = 1'b0;
	line_item_t cur_item;
	pixel_t     want;
	wire        calm = cycle_count >= 1000 && cycle_count < 1600;

	// rasterizer model state, at the block's widths but for the wider step count
	dim_t               img_w = WIDTH_RESET;
	dim_t               img_h = HEIGHT_RESET;
	bit                 walk_busy = 1'b0;
	logic signed [15:0] ep_x0 = '0, ep_y0 = '0, ep_x1 = '0, ep_y1 = '0;
	logic signed [16:0] walk_x = '0, walk_y = '0;
	logic signed [18:0] walk_err = '0;
	logic [16:0]        walk_steps = '0;
	logic [6:0]         brush_r = '0;
	logic signed [8:0]  arc_x = '0, arc_y = '0;
	logic signed [10:0] arc_d = '0;
	logic [2:0]         octant = '0;
	bit                 second_pass = 1'b0, circle_repeat = 1'b0, even_brush = 1'b0;

	function automatic int span(int a, int b);
		return a >= b ? a - b : b - a;
	endfunction

	function automatic int brush_of(logic [7:0] t);
		int r;
		r = (int'(t) - 1) / 2;
		return r > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : r;
	endfunction

	// one step of the midpoint circle walk
	function automatic void arc_step(inout int x, inout int y, inout int d);
		int e;
		e = 2 * (d + y) - 1;
		if (d < 0 && e <= 0) begin
			x++;
			d += 2 * x + 1;
		end else if (d > 0 && e > 0) begin
			y--;
			d -= 2 * y + 1;
		end else begin
			x++;
			y--;
			d += 2 * (x - y);
		end
	endfunction

	function automatic void ring_restart();
		arc_x = '0;
		arc_y = 9'(int'(brush_r));
		arc_d = 11'(1 - 2 * int'(brush_r));
		octant = '0;
	endfunction

	function automatic void pass_start(int shx, int shy);
		int ax, ay;
		ax = span(int'(ep_x1), int'(ep_x0));
		ay = span(int'(ep_y1), int'(ep_y0));
		walk_x = 17'(int'(ep_x0) + shx);
		walk_y = 17'(int'(ep_y0) + shy);
		walk_err = 19'(ay <= ax ? -ax : -ay);
		walk_steps = 17'(ax > ay ? ax : ay);
		circle_repeat = (ax == 0 && ay == 0);
		ring_restart();
	endfunction

	function automatic void line_advance();
		int ax, ay, sx, sy, e;
		ax = span(int'(ep_x1), int'(ep_x0));
		ay = span(int'(ep_y1), int'(ep_y0));
		sx = ep_x1 >= ep_x0 ? 1 : -1;
		sy = ep_y1 >= ep_y0 ? 1 : -1;
		e = int'(walk_err);
		if (ay <= ax) begin
			walk_x = 17'(int'(walk_x) + sx);
			e += 2 * ay;
			if (e > 0) begin
				e -= 2 * ax;
				walk_y = 17'(int'(walk_y) + sy);
			end
		end else begin
			walk_y = 17'(int'(walk_y) + sy);
			e += 2 * ax;
			if (e > 0) begin
				e -= 2 * ay;
				walk_x = 17'(int'(walk_x) + sx);
			end
		end
		walk_err = 19'(e);
	endfunction

	// moves to the next write; 0 when the command is done
	function automatic bit pixel_advance();
		int x, y, d;
		if (octant != OCT_LAST) begin
			octant = octant + 3'd1;
			return 1'b1;
		end
		octant = '0;
		x = int'(arc_x);
		y = int'(arc_y);
		d = int'(arc_d);
		arc_step(x, y, d);
		arc_x = 9'(x);
		arc_y = 9'(y);
		arc_d = 11'(d);
		if (y >= x)
			return 1'b1;
		ring_restart();
		if (circle_repeat) begin
			circle_repeat = 1'b0;
			return 1'b1;
		end
		if (walk_steps != '0) begin
			line_advance();
			walk_steps = walk_steps - 17'd1;
			return 1'b1;
		end
		if (!second_pass && even_brush) begin
			second_pass = 1'b1;
			if (span(int'(ep_x0), int'(ep_x1)) <= span(int'(ep_y0), int'(ep_y1)))
				pass_start(1, 0);
			else
				pass_start(0, 1);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void rasterize_item(line_item_t it);
		int wx, wy, cx, cy, px, py;
		bit more;
		pixel_t res;
		if (it.op == OP_START) begin
			ep_x0 = it.x0;
			ep_y0 = it.y0;
			ep_x1 = it.x1;
			ep_y1 = it.y1;
			brush_r = 7'(brush_of(it.thick));
			even_brush = !it.thick[0];
			second_pass = 1'b0;
			pass_start(0, 0);
			walk_busy = 1'b1;
			return;
		end
		if (!walk_busy)
			return;
		wx = int'(walk_x);
		wy = int'(walk_y);
		cx = int'(arc_x);
		cy = int'(arc_y);
		case (octant)
			3'd0: begin px = wx + cx; py = wy + cy; end
			3'd1: begin px = wx + cx; py = wy - cy; end
			3'd2: begin px = wx - cx; py = wy + cy; end
			3'd3: begin px = wx - cx; py = wy - cy; end
			3'd4: begin px = wx + cy; py = wy + cx; end
			3'd5: begin px = wx + cy; py = wy - cx; end
			3'd6: begin px = wx - cy; py = wy + cx; end
			default: begin px = wx - cy; py = wy - cx; end
		endcase
		res.px = 17'(px);
		res.py = 17'(py);
		res.vis = px >= 0 && py >= 0 && px < int'(img_w) && py < int'(img_h);
		more = pixel_advance();
		if (!more)
			walk_busy = 1'b0;
		res.last = !more;
		expected_pixels.push_back(res);
	endfunction

	// stimulus planning: number of writes a full command takes
	function automatic int writes_for_line(int x0, int y0, int x1, int y1, int thick);
		int steps, pts, x, y, d, ring;
		steps = span(x0, x1) > span(y0, y1) ? span(x0, x1) : span(y0, y1);
		pts = steps + 1 + (steps == 0 ? 1 : 0);
		x = 0;
		y = brush_of(8'(thick));
		d = 1 - 2 * y;
		ring = 1;
		arc_step(x, y, d);
		while (y >= x) begin
			ring++;
			arc_step(x, y, d);
		end
		return (thick % 2 == 0 ? 2 : 1) * pts * 8 * ring;
	endfunction

	function automatic int any_coord();
		logic signed [15:0] v;
		v = 16'($urandom);
		return int'(v);
	endfunction

	function automatic line_item_t next_item();
		line_item_t it;
		it.op = OP_NEXT;
		it.x0 = 16'($urandom);
		it.y0 = 16'($urandom);
		it.x1 = 16'($urandom);
		it.y1 = 16'($urandom);
		it.thick = 8'($urandom);
		return it;
	endfunction

	task automatic queue_nexts(int n);
		repeat (n) pending_items.push_back(next_item());
		if (gen_busy)
			phase_items += n;
	endtask

	task automatic queue_line(int x0, int y0, int x1, int y1, int thick, int nexts);
		line_item_t it;
		it.op = OP_START;
		it.x0 = 16'(x0);
		it.y0 = 16'(y0);
		it.x1 = 16'(x1);
		it.y1 = 16'(y1);
		it.thick = 8'(thick);
		pending_items.push_back(it);
		phase_items++;
		gen_busy = 1'b1;
		queue_nexts(nexts);
		gen_busy = nexts < writes_for_line(x0, y0, x1, y1, thick);
	endtask

	task automatic full_line(int x0, int y0, int x1, int y1, int thick);
		queue_line(x0, y0, x1, y1, thick, writes_for_line(x0, y0, x1, y1, thick));
	endtask

	task automatic random_lines(int w, int h, int budget);
		int sel, x0, y0, lim_x, lim_y, t, r;
		lim_x = w > 200 ? 200 : w;
		lim_y = h > 200 ? 200 : h;
		while (phase_items < budget) begin
			sel = $urandom_range(99);
			if (sel < 60) begin
				x0 = int'($urandom_range(lim_x + 16)) - 8;
				y0 = int'($urandom_range(lim_y + 16)) - 8;
				t = $urandom_range(99) < 80 ? $urandom_range(6) : $urandom_range(20);
				if (t > 6)
					full_line(x0, y0, x0, y0, t);
				else
					full_line(x0, y0, x0 + int'($urandom_range(10)) - 5,
						y0 + int'($urandom_range(10)) - 5, t);
			end else if (sel < 70) begin
				// lines hugging the corners of the coordinate range
				x0 = $urandom_range(1) ? 32767 : -32768;
				y0 = $urandom_range(1) ? 32767 : -32768;
				r = $urandom_range(4);
				t = $urandom_range(4);
				full_line(x0, y0, x0 > 0 ? x0 - r : x0 + r,
					y0 > 0 ? y0 - int'($urandom_range(4)) : y0 + int'($urandom_range(4)), t);
			end else if (sel < 90) begin
				// cut short by the next start
				queue_line(any_coord(), any_coord(), any_coord(), any_coord(),
					$urandom_range(255), $urandom_range(40));
			end else
				queue_nexts($urandom_range(1, 3));
		end
		// close the phase with a short complete command so the walker is idle
		full_line(int'($urandom_range(20)), int'($urandom_range(20)), 0, 0, 1);
		gen_busy = 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_items.size() != 0 || item_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(int w, int h);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= dim_t'(w);
		img_w = dim_t'(w);
		@(negedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= dim_t'(h);
		img_h = dim_t'(h);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(string name, logic [16:0] exp_v, logic [16:0] got_v);
		if (got_v !== exp_v) begin
			mismatch_count++;
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
		end
	endtask

	// driver: accepted transactions feed the model
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			rasterize_item(cur_item);
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_taken)) begin
			item_taken = 1'b0;
			if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
				cur_item = pending_items.pop_front();
				operation <= cur_item.op;
				start_x <= cur_item.x0;
				start_y <= cur_item.y0;
				end_x <= cur_item.x1;
				end_y <= cur_item.y1;
				thickness <= cur_item.thick;
				item_valid <= 1'b1;
			end else
				item_valid <= 1'b0;
		end
	end

	// monitor
	always @(negedge clk) pixel_stall <= !calm && $urandom_range(99) < 8;

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				if (expected_pixels.size() == 0) begin
					mismatch_count++;
					$error("unexpected pixel write at (%0d, %0d)", pixel_x, pixel_y);
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel_x", want.px, pixel_x);
					check_field("pixel_y", want.py, pixel_y);
					check_field("visible", 17'(want.vis), 17'(visible));
					check_field("last_write", 17'(want.last), 17'(last_write));
				end
			end
			if ((pixel_valid && !pixel_stall) || (item_valid && !item_stall))
				quiet_cycles = 0;
			else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("thick_line_rasterizer_unit test failed");
					$finish;
				end
			end
		end
	end

	initial begin
		int w, h;
		w = 640;
		h = 480;
		// directed: next while idle, full-range endpoints with widest brush cut short
		// by a new start, then a zero-length line with zero thickness (two passes)
		queue_nexts(1);
		queue_line(-32768, -32768, 32767, 32767, 255, 3);
		full_line(5, 5, 5, 5, 0);
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: begin w = 1; h = 1; end
				2: begin w = 32767; h = 32767; end
				3: begin w = 0; h = 0; end
				4: begin w = 150; h = 32767; end
				default: begin w = 640; h = 480; end
			endcase
			if (p > 0) begin
				drain();
				write_config(w, h);
				phase_items = 0;
			end
			random_lines(w, h, ITEM_BUDGET / PHASES - CLOSE_RESERVE);
		end
		drain();
		if (mismatch_count == 0)
			$display("thick_line_rasterizer_unit test passed");
		else
			$display("thick_line_rasterizer_unit test failed");
		$finish;
	end

endmodule
